// ===== sv/ovr_pkg.sv =====
// Shared types and pipeline constants for the orbit frame vector rotation block.
package ovr_pkg;

    localparam int WordW        = 32;
    localparam int MagW         = 64;
    localparam int NormW        = 31;
    localparam int RootW        = 32;
    localparam int NumW         = 62;
    localparam int QuoW         = 32;
    localparam int SqrtPerStage = 2;
    localparam int SqrtStages   = RootW / SqrtPerStage;
    localparam int DivPerStage  = 2;
    localparam int DivStages    = QuoW / DivPerStage;

    localparam int LatCross = 2;
    localparam int LatUnit  = 4 + SqrtStages + 1 + DivStages + 1;
    localparam int LatRot   = 6;
    localparam int LatTotal = LatCross + LatUnit + LatRot;

    typedef logic signed [WordW-1:0] t_word;
    typedef logic [MagW-1:0]         t_mag;

    // Item data that rides alongside the unit-vector pipelines
    typedef struct packed {
        logic                         action;
        logic                         degen;
        logic [2:0][WordW-1:0]        w;
    } t_side;

endpackage

// ===== sv/ovr_if.sv =====
// Valid/ready channel interfaces for input and result transactions.
interface ovr_in_if;
    import ovr_pkg::*;
    logic  valid;
    logic  ready;
    logic  action;
    t_word pos_x;
    t_word pos_y;
    t_word pos_z;
    t_word vel_x;
    t_word vel_y;
    t_word vel_z;
    t_word vec_a;
    t_word vec_b;
    t_word vec_c;
    modport source (output valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                    vec_a, vec_b, vec_c, input ready);
    modport sink (input valid, action, pos_x, pos_y, pos_z, vel_x, vel_y, vel_z,
                  vec_a, vec_b, vec_c, output ready);
endinterface

interface ovr_out_if;
    import ovr_pkg::*;
    logic  valid;
    logic  ready;
    t_word out_a;
    t_word out_b;
    t_word out_c;
    logic  degenerate;
    modport source (output valid, out_a, out_b, out_c, degenerate, input ready);
    modport sink (input valid, out_a, out_b, out_c, degenerate, output ready);
endinterface

// ===== sv/orbit_frame_vector_rotation_top.sv =====
// Throughput: one transaction per cycle unless the result stalls; every stage is
// registered and fully pipelined (two square-root bits and two quotient bits per stage
// set the depth).
// A stalled result freezes the whole pipeline; no transaction is lost or repeated.
// Reset (synchronous, active low) clears all stage valid bits; payload is not reset.
module orbit_frame_vector_rotation_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    ovr_in_if.sink     i_in,
    ovr_out_if.source  o_out
);
    import ovr_pkg::*;

    logic          r_vld [LatTotal];
    logic          w_en;
    t_word         w_pos [3];
    t_word         w_vel [3];
    t_mag          w_hmag [3];
    logic [2:0]    w_hneg;
    t_mag          w_pmag [3];
    logic [2:0]    w_pneg;
    logic          w_degen;
    t_side         r_sl [LatCross+LatUnit];
    t_side         n_sl0;
    t_word         w_h [3];
    t_word         w_r [3];
    t_word         w_out [3];
    logic          w_odegen;

    assign w_en       = !r_vld[LatTotal-1] || o_out.ready;
    assign i_in.ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < LatTotal; s++) begin
                r_vld[s] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_in.valid;
            for (int s = 1; s < LatTotal; s++) begin
                r_vld[s] <= r_vld[s-1];
            end
        end
    end

    assign w_pos = '{i_in.pos_x, i_in.pos_y, i_in.pos_z};
    assign w_vel = '{i_in.vel_x, i_in.vel_y, i_in.vel_z};

    ovr_cross u_cross (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_pos   (w_pos),
        .i_vel   (w_vel),
        .o_hmag  (w_hmag),
        .o_hneg  (w_hneg),
        .o_pmag  (w_pmag),
        .o_pneg  (w_pneg),
        .o_degen (w_degen)
    );

    assign n_sl0 = '{action: i_in.action, degen: 1'b0,
                     w: {i_in.vec_c, i_in.vec_b, i_in.vec_a}};

    // degenerate flag joins the side data once the cross product stage has it
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_sl[0] <= n_sl0;
            for (int s = 1; s < LatCross+LatUnit; s++) begin
                if (s == LatCross) begin
                    r_sl[s] <= '{action: r_sl[s-1].action, degen: w_degen,
                                 w: r_sl[s-1].w};
                end else begin
                    r_sl[s] <= r_sl[s-1];
                end
            end
        end
    end

    ovr_unit u_unit_h (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_hmag),
        .i_neg (w_hneg),
        .o_u   (w_h)
    );

    ovr_unit u_unit_r (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_mag (w_pmag),
        .i_neg (w_pneg),
        .o_u   (w_r)
    );

    ovr_rotate u_rotate (
        .i_clk   (i_clk),
        .i_en    (w_en),
        .i_r     (w_r),
        .i_h     (w_h),
        .i_side  (r_sl[LatCross+LatUnit-1]),
        .o_out   (w_out),
        .o_degen (w_odegen)
    );

    assign o_out.valid      = r_vld[LatTotal-1];
    assign o_out.out_a      = w_out[0];
    assign o_out.out_b      = w_out[1];
    assign o_out.out_c      = w_out[2];
    assign o_out.degenerate = w_odegen;

endmodule

// ===== sv/ovr_cross.sv =====
// Cross product p x v as sign/magnitude, position magnitudes and degenerate detect.
module ovr_cross (
    input  logic           i_clk,
    input  logic           i_en,
    input  ovr_pkg::t_word i_pos [3],
    input  ovr_pkg::t_word i_vel [3],
    output ovr_pkg::t_mag  o_hmag [3],
    output logic [2:0]     o_hneg,
    output ovr_pkg::t_mag  o_pmag [3],
    output logic [2:0]     o_pneg,
    output logic           o_degen
);
    import ovr_pkg::*;

    logic signed [2*WordW-1:0] r_pa [3];
    logic signed [2*WordW-1:0] r_pb [3];
    t_word                     r_pos [3];
    t_mag                      r_hmag [3];
    logic [2:0]                r_hneg;
    t_mag                      r_pmag [3];
    logic [2:0]                r_pneg;
    logic                      r_degen;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa[0] <= i_pos[1] * i_vel[2];
            r_pb[0] <= i_pos[2] * i_vel[1];
            r_pa[1] <= i_pos[2] * i_vel[0];
            r_pb[1] <= i_pos[0] * i_vel[2];
            r_pa[2] <= i_pos[0] * i_vel[1];
            r_pb[2] <= i_pos[1] * i_vel[0];
            for (int i = 0; i < 3; i++) begin
                r_pos[i] <= i_pos[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_pa[i] >= r_pb[i]) begin
                    r_hmag[i] <= MagW'(r_pa[i] - r_pb[i]);
                    r_hneg[i] <= 1'b0;
                end else begin
                    r_hmag[i] <= MagW'(r_pb[i] - r_pa[i]);
                    r_hneg[i] <= 1'b1;
                end
                r_pneg[i] <= r_pos[i][WordW-1];
                r_pmag[i] <= {{(MagW-WordW){1'b0}},
                              (r_pos[i][WordW-1] ? WordW'(-r_pos[i]) : WordW'(r_pos[i]))};
            end
            r_degen <= ((r_pos[0] == '0) && (r_pos[1] == '0) && (r_pos[2] == '0)) ||
                       ((r_pa[0] == r_pb[0]) && (r_pa[1] == r_pb[1]) &&
                        (r_pa[2] == r_pb[2]));
        end
    end

    assign o_hmag  = r_hmag;
    assign o_hneg  = r_hneg;
    assign o_pmag  = r_pmag;
    assign o_pneg  = r_pneg;
    assign o_degen = r_degen;

endmodule

// ===== sv/ovr_isqrt.sv =====
// Pipelined floor square root of a 64-bit value, two root bits per stage.
module ovr_isqrt (
    input  logic             i_clk,
    input  logic             i_en,
    input  ovr_pkg::t_mag    i_x,
    output logic [31:0]      o_root
);
    import ovr_pkg::*;

    typedef struct packed {
        logic [MagW-1:0]  x;
        logic [RootW+3:0] rem;
        logic [RootW-1:0] root;
    } t_sq;

    function automatic t_sq sq_step(t_sq a);
        t_sq              b;
        logic [RootW+3:0] trial;
        b.rem = {a.rem[RootW+1:0], a.x[MagW-1 -: 2]};
        b.x   = {a.x[MagW-3:0], 2'b00};
        trial = {2'b00, a.root, 2'b01};
        if (b.rem >= trial) begin
            b.rem  = b.rem - trial;
            b.root = {a.root[RootW-2:0], 1'b1};
        end else begin
            b.root = {a.root[RootW-2:0], 1'b0};
        end
        return b;
    endfunction

    t_sq r_st [SqrtStages];
    t_sq n_st [SqrtStages];

    always_comb begin
        for (int s = 0; s < SqrtStages; s++) begin
            if (s == 0) begin
                n_st[s] = {i_x, {(RootW+4){1'b0}}, {RootW{1'b0}}};
            end else begin
                n_st[s] = r_st[s-1];
            end
            for (int k = 0; k < SqrtPerStage; k++) begin
                n_st[s] = sq_step(n_st[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < SqrtStages; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_root = r_st[SqrtStages-1].root;

endmodule

// ===== sv/ovr_div.sv =====
// Pipelined restoring divider, 62-bit numerator by 32-bit divisor, two quotient bits a stage.
module ovr_div (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  logic [ovr_pkg::NumW-1:0] i_num,
    input  logic [31:0]              i_den,
    output logic [ovr_pkg::QuoW-1:0] o_quo
);
    import ovr_pkg::*;

    typedef struct packed {
        logic [QuoW-1:0] lo;
        logic [QuoW:0]   rem;
        logic [QuoW-1:0] q;
        logic [31:0]     den;
    } t_dv;

    function automatic t_dv dv_step(t_dv a);
        t_dv b;
        b     = a;
        b.rem = {a.rem[QuoW-1:0], a.lo[QuoW-1]};
        b.lo  = {a.lo[QuoW-2:0], 1'b0};
        if (b.rem >= {1'b0, a.den}) begin
            b.rem = b.rem - {1'b0, a.den};
            b.q   = {a.q[QuoW-2:0], 1'b1};
        end else begin
            b.q   = {a.q[QuoW-2:0], 1'b0};
        end
        return b;
    endfunction

    t_dv r_st [DivStages];
    t_dv n_st [DivStages];

    // quotient stays below 2^32, so the top 30 numerator bits seed the remainder
    always_comb begin
        for (int s = 0; s < DivStages; s++) begin
            if (s == 0) begin
                n_st[s] = {i_num[QuoW-1:0], {(2*QuoW-NumW+1){1'b0}}, i_num[NumW-1:QuoW],
                           {QuoW{1'b0}}, i_den};
            end else begin
                n_st[s] = r_st[s-1];
            end
            for (int k = 0; k < DivPerStage; k++) begin
                n_st[s] = dv_step(n_st[s]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int s = 0; s < DivStages; s++) begin
                r_st[s] <= n_st[s];
            end
        end
    end

    assign o_quo = r_st[DivStages-1].q;

endmodule

// ===== sv/ovr_unit.sv =====
// Q2.30 unit vector from a sign/magnitude 3-vector: scale, square, sqrt, divide, sign.
module ovr_unit (
    input  logic           i_clk,
    input  logic           i_en,
    input  ovr_pkg::t_mag  i_mag [3],
    input  logic [2:0]     i_neg,
    output ovr_pkg::t_word o_u [3]
);
    import ovr_pkg::*;

    typedef struct packed {
        logic [2:0][NormW-1:0] m;
        logic [2:0]            neg;
    } t_mn;

    logic [MagW-1:0]      w_or;
    logic [5:0]           w_k;
    logic [5:0]           r_k;
    t_mag                 r_mag [3];
    logic [2:0]           r_neg1;
    logic [NormW-1:0]     r_m [3];
    logic [2:0]           r_neg2;
    logic [2*NormW-1:0]   r_sq [3];
    t_mag                 r_sum;
    t_mn                  r_md [SqrtStages+2];
    logic [RootW-1:0]     w_root;
    logic [NumW-1:0]      r_num [3];
    logic [RootW-1:0]     r_den;
    logic [2:0]           r_nd [DivStages+1];
    logic [QuoW-1:0]      w_quo [3];
    t_word                r_u [3];

    // leading one of the OR is the leading one of the largest component
    always_comb begin
        w_or = i_mag[0] | i_mag[1] | i_mag[2];
        w_k  = '0;
        for (int b = 0; b < MagW; b++) begin
            if (w_or[b]) begin
                w_k = 6'(b);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_k    <= w_k;
            r_neg1 <= i_neg;
            for (int i = 0; i < 3; i++) begin
                r_mag[i] <= i_mag[i];
            end
            r_neg2 <= r_neg1;
            for (int i = 0; i < 3; i++) begin
                if (r_k > 6'(NormW-1)) begin
                    r_m[i] <= NormW'(r_mag[i] >> (r_k - 6'(NormW-1)));
                end else begin
                    r_m[i] <= NormW'(r_mag[i] << (6'(NormW-1) - r_k));
                end
            end
            for (int i = 0; i < 3; i++) begin
                r_sq[i] <= r_m[i] * r_m[i];
            end
            r_sum <= MagW'(r_sq[0]) + MagW'(r_sq[1]) + MagW'(r_sq[2]);
            r_md[0] <= {r_m[2], r_m[1], r_m[0], r_neg2};
            for (int s = 1; s < SqrtStages+2; s++) begin
                r_md[s] <= r_md[s-1];
            end
        end
    end

    ovr_isqrt u_isqrt (
        .i_clk  (i_clk),
        .i_en   (i_en),
        .i_x    (r_sum),
        .o_root (w_root)
    );

    // rounded numerator m * 2^30 + n/2
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_num[i] <= NumW'({r_md[SqrtStages+1].m[i], {(NormW-1){1'b0}}}) +
                            NumW'(w_root[RootW-1:1]);
            end
            r_den   <= w_root;
            r_nd[0] <= r_md[SqrtStages+1].neg;
            for (int s = 1; s < DivStages+1; s++) begin
                r_nd[s] <= r_nd[s-1];
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_div
        ovr_div u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_num (r_num[g]),
            .i_den (r_den),
            .o_quo (w_quo[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_u[i] <= r_nd[DivStages][i] ? WordW'(-w_quo[i]) : WordW'(w_quo[i]);
            end
        end
    end

    assign o_u = r_u;

endmodule

// ===== sv/ovr_rotate.sv =====
// t = h x r, then the rotation products, sums, rounding and saturation into the result register.
module ovr_rotate (
    input  logic           i_clk,
    input  logic           i_en,
    input  ovr_pkg::t_word i_r [3],
    input  ovr_pkg::t_word i_h [3],
    input  ovr_pkg::t_side i_side,
    output ovr_pkg::t_word o_out [3],
    output logic           o_degen
);
    import ovr_pkg::*;

    localparam logic signed [2*WordW-1:0] HalfP = 64'sd536870912;
    localparam logic signed [2*WordW-1:0] HalfN = 64'sd536870911;
    localparam logic signed [2*WordW+1:0] SHalfP = 66'sd536870912;
    localparam logic signed [2*WordW+1:0] SHalfN = 66'sd536870911;
    localparam logic signed [2*WordW+1:0] SatMax = 66'sd2147483647;
    localparam logic signed [2*WordW+1:0] SatMin = -66'sd2147483648;

    logic signed [2*WordW-1:0] r_pa [3];
    logic signed [2*WordW-1:0] r_pb [3];
    logic signed [2*WordW-1:0] r_d [3];
    logic signed [2*WordW-1:0] w_rnd [3];
    t_word                     r_r1 [3], r_h1 [3], r_r2 [3], r_h2 [3], r_r3 [3], r_h3 [3];
    t_word                     r_t3 [3];
    t_side                     r_s1, r_s2, r_s3, r_s4, r_s5;
    t_word                     w_m [3][3];
    logic signed [2*WordW-1:0] r_pr [3][3];
    logic signed [2*WordW+1:0] r_acc [3];
    logic signed [2*WordW+1:0] w_v [3];
    t_word                     r_out [3];
    logic                      r_degen;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pa[0] <= i_h[1] * i_r[2];
            r_pb[0] <= i_h[2] * i_r[1];
            r_pa[1] <= i_h[2] * i_r[0];
            r_pb[1] <= i_h[0] * i_r[2];
            r_pa[2] <= i_h[0] * i_r[1];
            r_pb[2] <= i_h[1] * i_r[0];
            r_r1 <= i_r;
            r_h1 <= i_h;
            r_s1 <= i_side;
            for (int i = 0; i < 3; i++) begin
                r_d[i] <= r_pa[i] - r_pb[i];
            end
            r_r2 <= r_r1;
            r_h2 <= r_h1;
            r_s2 <= r_s1;
            for (int i = 0; i < 3; i++) begin
                r_t3[i] <= WordW'(w_rnd[i] >>> (NormW-1));
            end
            r_r3 <= r_r2;
            r_h3 <= r_h2;
            r_s3 <= r_s2;
        end
    end

    // half away from zero: add half, one less for negative values, then floor
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_rnd[i] = r_d[i] + (r_d[i][2*WordW-1] ? HalfN : HalfP);
        end
    end

    // forward uses columns r, t, h; backward uses them as rows
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (!r_s3.action) begin
                w_m[i][0] = r_r3[i];
                w_m[i][1] = r_t3[i];
                w_m[i][2] = r_h3[i];
            end else begin
                w_m[0][i] = r_r3[i];
                w_m[1][i] = r_t3[i];
                w_m[2][i] = r_h3[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r_pr[i][j] <= w_m[i][j] * signed'(r_s3.w[j]);
                end
            end
            r_s4 <= r_s3;
            for (int i = 0; i < 3; i++) begin
                r_acc[i] <= (2*WordW+2)'(r_pr[i][0]) + (2*WordW+2)'(r_pr[i][1]) +
                            (2*WordW+2)'(r_pr[i][2]);
            end
            r_s5 <= r_s4;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_v[i] = (r_acc[i] + (r_acc[i][2*WordW+1] ? SHalfN : SHalfP)) >>> (NormW-1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (r_s5.degen) begin
                    r_out[i] <= '0;
                end else if (w_v[i] > SatMax) begin
                    r_out[i] <= WordW'(SatMax);
                end else if (w_v[i] < SatMin) begin
                    r_out[i] <= WordW'(SatMin);
                end else begin
                    r_out[i] <= WordW'(w_v[i]);
                end
            end
            r_degen <= r_s5.degen;
        end
    end

    assign o_out   = r_out;
    assign o_degen = r_degen;

endmodule

// ===== sv/ovr_checker.sv =====
// Port-level checks on the frame rotation top level, attached by bind.
module ovr_checker (
    input logic           i_clk,
    input logic           i_rst_n,
    input logic           i_in_ready,
    input logic           i_out_valid,
    input logic           i_out_ready,
    input ovr_pkg::t_word i_out_a,
    input ovr_pkg::t_word i_out_b,
    input ovr_pkg::t_word i_out_c,
    input logic           i_degenerate
);

    // a stalled result transaction holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid &&
            $stable({i_out_a, i_out_b, i_out_c, i_degenerate}))
        else $error("result changed while stalled");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_degenerate |-> i_out_a == '0 && i_out_b == '0 && i_out_c == '0)
        else $error("degenerate result with nonzero vector");

    a_ready_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_out_valid |-> i_in_ready)
        else $error("input stalled with empty output register");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid straight after reset");

endmodule

bind orbit_frame_vector_rotation_top ovr_checker u_ovr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (i_in.ready),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_out_a      (o_out.out_a),
    .i_out_b      (o_out.out_b),
    .i_out_c      (o_out.out_c),
    .i_degenerate (o_out.degenerate)
);

// ===== bench/orbit_frame_vector_rotation_top_tb.sv =====
// Self-checking bench for the orbit frame vector rotation pipeline.
module orbit_frame_vector_rotation_top_tb;
    import ovr_pkg::*;

    typedef struct {
        logic  action;
        t_word p[3];
        t_word v[3];
        t_word w[3];
    } t_item;

    typedef struct {
        t_word o[3];
        logic  degen;
    } t_rot;

    localparam int IdleLimit = 4000;
    localparam int Drain     = LatTotal + 20;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ovr_in_if  in_ch ();
    ovr_out_if out_ch ();

    orbit_frame_vector_rotation_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch.sink),
        .o_out   (out_ch.source)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_item pending_items[$];
    t_rot  expected_rots[$];
    int    n_errors = 0;
    int    n_sent = 0;
    int    n_seen = 0;
    int    n_degen = 0;
    int    idle_cycles = 0;
    bit    calm = 1'b0;
    bit    hold = 1'b0;

    function automatic longint rnd30(longint x);
        if (x >= 0) return (x + (64'sd1 <<< 29)) >>> 30;
        return -((-x + (64'sd1 <<< 29)) >>> 30);
    endfunction

    // Normalise sign-magnitude components to Q2.30
    function automatic void make_unit(input logic [63:0] mag[3], input bit neg[3],
                                      output longint u[3]);
        logic [63:0] m[3];
        logic [63:0] mx, sum, n, rem, bitv, res;
        logic [127:0] q;
        mx = mag[0];
        if (mag[1] > mx) mx = mag[1];
        if (mag[2] > mx) mx = mag[2];
        for (int i = 0; i < 3; i++) m[i] = mag[i];
        while (mx >= (64'd1 << 31)) begin
            mx = mx >> 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
        end
        while (mx < (64'd1 << 30)) begin
            mx = mx << 1;
            for (int i = 0; i < 3; i++) m[i] = m[i] << 1;
        end
        sum = m[0]*m[0] + m[1]*m[1] + m[2]*m[2];
        rem = sum;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > rem) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        n = res;
        for (int i = 0; i < 3; i++) begin
            q = ({64'd0, m[i]} << 30) + (n >> 1);
            q = q / n;
            u[i] = neg[i] ? -longint'(q[63:0]) : longint'(q[63:0]);
        end
    endfunction

    function automatic t_word clamp_word(longint acc);
        longint x;
        x = rnd30(acc);
        if (x > 64'sh7FFFFFFF) x = 64'sh7FFFFFFF;
        if (x < -64'sh80000000) x = -64'sh80000000;
        return t_word'(x[31:0]);
    endfunction

    function automatic t_rot rotate_vector(t_item it);
        t_rot   rv;
        longint p[3], v[3], w[3], r[3], h[3], t[3], a, b, acc;
        logic [63:0] mag[3];
        bit     neg[3];
        for (int i = 0; i < 3; i++) begin
            p[i] = longint'(it.p[i]);
            v[i] = longint'(it.v[i]);
            w[i] = longint'(it.w[i]);
        end
        for (int i = 0; i < 3; i++) begin
            a = p[(i+1)%3] * v[(i+2)%3];
            b = p[(i+2)%3] * v[(i+1)%3];
            neg[i] = a < b;
            mag[i] = neg[i] ? (64'(b) - 64'(a)) : (64'(a) - 64'(b));
        end
        rv.degen = 1'b0;
        if ((p[0] == 0 && p[1] == 0 && p[2] == 0) ||
            (mag[0] == 0 && mag[1] == 0 && mag[2] == 0)) begin
            rv.degen = 1'b1;
            for (int i = 0; i < 3; i++) rv.o[i] = '0;
            return rv;
        end
        make_unit(mag, neg, h);
        for (int i = 0; i < 3; i++) begin
            neg[i] = p[i] < 0;
            mag[i] = neg[i] ? 64'(-p[i]) : 64'(p[i]);
        end
        make_unit(mag, neg, r);
        for (int i = 0; i < 3; i++)
            t[i] = rnd30(h[(i+1)%3] * r[(i+2)%3] - h[(i+2)%3] * r[(i+1)%3]);
        for (int i = 0; i < 3; i++) begin
            if (!it.action)
                acc = r[i]*w[0] + t[i]*w[1] + h[i]*w[2];
            else if (i == 0)
                acc = r[0]*w[0] + r[1]*w[1] + r[2]*w[2];
            else if (i == 1)
                acc = t[0]*w[0] + t[1]*w[1] + t[2]*w[2];
            else
                acc = h[0]*w[0] + h[1]*w[1] + h[2]*w[2];
            rv.o[i] = clamp_word(acc);
        end
        return rv;
    endfunction

    function automatic t_word rnd_word();
        case ($urandom_range(0, 9))
            0: return 32'sh7FFFFFFF;
            1: return 32'sh80000000;
            2: return t_word'($urandom_range(0, 8)) - 4;
            3: return t_word'($urandom) >>> $urandom_range(0, 31);
            default: return t_word'($urandom);
        endcase
    endfunction

    task automatic add_item(logic act, t_word px, t_word py, t_word pz,
                            t_word vx, t_word vy, t_word vz,
                            t_word a, t_word b, t_word c);
        t_item it;
        it.action = act;
        it.p[0] = px; it.p[1] = py; it.p[2] = pz;
        it.v[0] = vx; it.v[1] = vy; it.v[2] = vz;
        it.w[0] = a;  it.w[1] = b;  it.w[2] = c;
        pending_items.push_back(it);
    endtask

    // Driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_ch.valid <= 1'b0;
        end else if (!in_ch.valid || in_ch.ready) begin
            if (in_ch.valid) n_sent <= n_sent + 1;
            if (pending_items.size() != 0 && !hold &&
                (calm || $urandom_range(0, 99) >= 10)) begin
                t_item it;
                it = pending_items.pop_front();
                expected_rots.push_back(rotate_vector(it));
                in_ch.valid  <= 1'b1;
                in_ch.action <= it.action;
                in_ch.pos_x <= it.p[0]; in_ch.pos_y <= it.p[1]; in_ch.pos_z <= it.p[2];
                in_ch.vel_x <= it.v[0]; in_ch.vel_y <= it.v[1]; in_ch.vel_z <= it.v[2];
                in_ch.vec_a <= it.w[0]; in_ch.vec_b <= it.w[1]; in_ch.vec_c <= it.w[2];
            end else begin
                in_ch.valid <= 1'b0;
            end
        end
    end

    // Monitor and result sink
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= calm || ($urandom_range(0, 99) >= 10);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready) begin
                n_seen <= n_seen + 1;
                if (expected_rots.size() == 0) begin
                    $display("%0t: unexpected result a=%0d b=%0d c=%0d deg=%0b", $time,
                             out_ch.out_a, out_ch.out_b, out_ch.out_c, out_ch.degenerate);
                    n_errors <= n_errors + 1;
                end else begin
                    t_rot e;
                    e = expected_rots.pop_front();
                    if (out_ch.out_a !== e.o[0] || out_ch.out_b !== e.o[1] ||
                        out_ch.out_c !== e.o[2] || out_ch.degenerate !== e.degen) begin
                        $display("%0t: mismatch exp a=%0d b=%0d c=%0d deg=%0b", $time,
                                 e.o[0], e.o[1], e.o[2], e.degen);
                        $display("%0t:          act a=%0d b=%0d c=%0d deg=%0b", $time,
                                 out_ch.out_a, out_ch.out_b, out_ch.out_c,
                                 out_ch.degenerate);
                        n_errors <= n_errors + 1;
                    end
                    if (e.degen) n_degen <= n_degen + 1;
                end
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        if (idle_cycles >= IdleLimit) begin
            $display("orbit_frame_vector_rotation_top_tb: errors");
            $finish;
        end
    end

    initial begin
        in_ch.valid = 1'b0;
        in_ch.action = 1'b0;
        {in_ch.pos_x, in_ch.pos_y, in_ch.pos_z} = '0;
        {in_ch.vel_x, in_ch.vel_y, in_ch.vel_z} = '0;
        {in_ch.vec_a, in_ch.vec_b, in_ch.vec_c} = '0;
        out_ch.ready = 1'b0;

        // Directed: axes, extremes, both degenerate cases
        add_item(0, 1000, 0, 0, 0, 1, 0, 5, 7, 9);
        add_item(1, 1000, 0, 0, 0, 1, 0, 5, 7, 9);
        add_item(0, 0, 0, 0, 3, 4, 5, 1, 2, 3);
        add_item(1, 0, 0, 0, 0, 0, 0, 1, 2, 3);
        add_item(0, 10, 20, 30, 20, 40, 60, 1, 2, 3);
        add_item(1, 5, 5, 5, 0, 0, 0, 1, 2, 3);
        add_item(0, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        add_item(1, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh80000000, 0,
                 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
        add_item(0, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                 32'sh80000000, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_item(1, 32'sh80000000, 32'sh80000000, 32'sh80000000, 32'sh7FFFFFFF,
                 32'sh80000000, 1, 32'sh80000000, 32'sh80000000, 32'sh80000000);
        add_item(0, 32'sh80000000, 0, 0, 0, 32'sh80000000, 0, -1, -1, -1);
        add_item(1, -1, 1, -1, 1, 1, 1, 32'sh80000000, 32'sh7FFFFFFF, 0);
        add_item(0, 1, 0, 0, 0, 0, 1, 0, 0, 0);
        add_item(1, 7000000, -3, 2, -5, 900000, 11, 12345, -6789, 1);

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0 && expected_rots.size() == 0);
        repeat (Drain) @(posedge i_clk);

        for (int k = 0; k < 850; k++) begin
            t_word px, py, pz, vx, vy, vz;
            px = rnd_word(); py = rnd_word(); pz = rnd_word();
            vx = rnd_word(); vy = rnd_word(); vz = rnd_word();
            if ($urandom_range(0, 29) == 0) begin
                vx = px; vy = py; vz = pz;
            end
            add_item($urandom_range(0, 1), px, py, pz, vx, vy, vz,
                     rnd_word(), rnd_word(), rnd_word());
            if (k == 300) begin
                wait (pending_items.size() == 0);
                hold = 1'b1;
                wait (expected_rots.size() == 0);
                @(posedge i_clk);
                hold = 1'b0;
                calm = 1'b1;
            end
            // the stretch without idling lasts until this batch has gone out
            if (k == 550) begin
                wait (pending_items.size() == 0);
                calm = 1'b0;
            end
        end

        wait (pending_items.size() == 0 && expected_rots.size() == 0);
        repeat (Drain) @(posedge i_clk);
        $display("Sent %0d and checked %0d transactions in both directions, %0d degenerate,",
                 n_sent, n_seen, n_degen);
        $display("with field extremes and random stalls on both channels.");
        if (n_errors == 0)
            $display("orbit_frame_vector_rotation_top_tb: clean");
        else
            $display("orbit_frame_vector_rotation_top_tb: errors");
        $finish;
    end
endmodule
